FILE: hw/rtl/slxfr_pkg.sv
// Shared types and constants of the sync/type/length/XOR frame receiver.
package slxfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam logic [ByteW-1:0] SyncReset = 8'hAA;

  // Receiver phase, one-hot
  typedef enum logic [4:0] {
    PhHunt    = 5'b00001,
    PhType    = 5'b00010,
    PhLength  = 5'b00100,
    PhPayload = 5'b01000,
    PhCheck   = 5'b10000
  } phase_e;

  // One result item from the frame parser
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] byte_index;
    logic             end_of_frame;
    logic             checksum_ok;
  } result_t;

endpackage

FILE: hw/rtl/slxfr_core.sv
// Frame parser: phase register, header capture, payload count and running XOR.
module slxfr_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,     // byte transfer this cycle
  input  logic [slxfr_pkg::ByteW-1:0] byte_i,
  input  logic [slxfr_pkg::ByteW-1:0] sync_value_i,
  output slxfr_pkg::result_t          result_o
);

  slxfr_pkg::phase_e           phase_q, phase_d;
  logic [slxfr_pkg::ByteW-1:0] type_q, type_d;
  logic [slxfr_pkg::ByteW-1:0] length_q, length_d;
  logic [slxfr_pkg::ByteW-1:0] count_q, count_d;
  logic [slxfr_pkg::ByteW-1:0] xor_q, xor_d;
  logic [slxfr_pkg::ByteW-1:0] count_inc;

  assign count_inc = count_q + slxfr_pkg::ByteW'(1);

  // Advance the phase and build the result for the incoming byte
  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    length_d = length_q;
    count_d  = count_q;
    xor_d    = xor_q;
    result_o = '0;
    result_o.frame_type   = type_q;
    result_o.frame_length = length_q;
    if (take_i) begin
      case (phase_q)
        slxfr_pkg::PhType: begin
          type_d  = byte_i;
          xor_d   = byte_i;
          phase_d = slxfr_pkg::PhLength;
        end
        slxfr_pkg::PhLength: begin
          length_d = byte_i;
          xor_d    = xor_q ^ byte_i;
          count_d  = '0;
          phase_d  = (byte_i == '0) ? slxfr_pkg::PhCheck : slxfr_pkg::PhPayload;
        end
        slxfr_pkg::PhPayload: begin
          xor_d   = xor_q ^ byte_i;
          count_d = count_inc;
          if (count_inc == length_q) begin
            phase_d = slxfr_pkg::PhCheck;
          end
          result_o.valid      = 1'b1;
          result_o.data_byte  = byte_i;
          result_o.byte_index = count_q;
        end
        slxfr_pkg::PhCheck: begin
          phase_d               = slxfr_pkg::PhHunt;
          result_o.valid        = 1'b1;
          result_o.end_of_frame = 1'b1;
          result_o.checksum_ok  = (xor_q == byte_i);
        end
        default: begin
          // Hunt: drop everything but the sync byte
          phase_d = (byte_i == sync_value_i) ? slxfr_pkg::PhType : slxfr_pkg::PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= slxfr_pkg::PhHunt;
      type_q   <= '0;
      length_q <= '0;
      count_q  <= '0;
      xor_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      length_q <= length_d;
      count_q  <= count_d;
      xor_q    <= xor_d;
    end
  end

endmodule

FILE: hw/rtl/sync_length_xor_frame_receiver_top.sv
// Top level of the sync/type/length/XOR frame receiver with its output register.
// Results: a payload or checksum byte gives its result in the cycle after its transfer.
// Throughput: one byte per cycle; the input stalls only while a held result
//   is not taken by the downstream side (single output register).
// Reset: phase returns to hunting, header, count and XOR clear to zero,
//   sync value returns to 0xAA, and the output register empties.
module sync_length_xor_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: sync value
  input  logic        sync_we_i,
  input  logic [7:0]  sync_wdata_i,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [15:8] frame_type, [23:16] frame_length, [31:24] byte_index
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,   // end_of_frame
  output logic        m_axis_tuser    // [0] checksum_ok
);

  logic [slxfr_pkg::ByteW-1:0] sync_q, sync_d;
  logic                        take;
  slxfr_pkg::result_t          result;
  slxfr_pkg::result_t          out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  // Hold the sync value until written
  assign sync_d = sync_we_i ? sync_wdata_i : sync_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  slxfr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_i       (s_axis_tdata),
    .sync_value_i (sync_q),
    .result_o     (result)
  );

  // Drain the output register on a transfer, load it with a new result
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (result.valid) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= slxfr_pkg::SyncReset;
      out_valid_q <= 1'b0;
    end else begin
      sync_q      <= sync_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.byte_index, out_q.frame_length,
                          out_q.frame_type, out_q.data_byte};
  assign m_axis_tlast  = out_q.end_of_frame;
  assign m_axis_tuser  = out_q.checksum_ok;

endmodule

FILE: hw/rtl/slxfr_checker.sv
// Port-level checks of the frame receiver, bound to its top level.
module slxfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input is open whenever no result is held
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // End-of-frame result carries zero data byte and index
  a_eof_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[7:0] == 8'h00 && m_axis_tdata[31:24] == 8'h00)
    else $error("end-of-frame result with payload fields");

  // Payload results never flag checksum pass
  a_payload_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("checksum flag on payload result");

endmodule

bind sync_length_xor_frame_receiver_top slxfr_checker u_slxfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sync_length_xor_frame_checker.sv
// Scoreboard for the frame receiver: mirrors its parser and checks every result transfer.
module sync_length_xor_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sync_we_i,
  input  logic [7:0]  sync_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [15:8] frame_type, [23:16] frame_length, [31:24] byte_index
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,   // end_of_frame
  input  logic        m_axis_tuser,   // [0] checksum_ok
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the parser state
  slxfr_pkg::phase_e  rx_phase;
  logic [7:0]         sync_val;
  logic [7:0]         hdr_type;
  logic [7:0]         hdr_length;
  logic [7:0]         pay_count;
  logic [7:0]         xor_acc;
  slxfr_pkg::result_t frame_results[$];
  int unsigned        mismatches = 0;

  // Advance the mirrored parser by one received byte, queue any result it gives
  task automatic take_byte(input logic [7:0] b);
    slxfr_pkg::result_t r;
    r = '0;
    r.valid = 1'b1;
    case (rx_phase)
      slxfr_pkg::PhType: begin
        hdr_type = b;
        xor_acc  = b;
        rx_phase = slxfr_pkg::PhLength;
      end
      slxfr_pkg::PhLength: begin
        hdr_length = b;
        xor_acc    = xor_acc ^ b;
        pay_count  = 8'd0;
        if (b == 8'd0) rx_phase = slxfr_pkg::PhCheck;
        else rx_phase = slxfr_pkg::PhPayload;
      end
      slxfr_pkg::PhPayload: begin
        r.data_byte    = b;
        r.frame_type   = hdr_type;
        r.frame_length = hdr_length;
        r.byte_index   = pay_count;
        xor_acc        = xor_acc ^ b;
        pay_count      = pay_count + 8'd1;
        if (pay_count == hdr_length) rx_phase = slxfr_pkg::PhCheck;
        frame_results.push_back(r);
      end
      slxfr_pkg::PhCheck: begin
        r.frame_type   = hdr_type;
        r.frame_length = hdr_length;
        r.end_of_frame = 1'b1;
        r.checksum_ok  = (xor_acc == b);
        rx_phase       = slxfr_pkg::PhHunt;
        frame_results.push_back(r);
      end
      default: begin
        // hunting: only the sync byte opens a frame
        if (b == sync_val) rx_phase = slxfr_pkg::PhType;
        else rx_phase = slxfr_pkg::PhHunt;
      end
    endcase
  endtask

  // Sample both channels and the register port at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    slxfr_pkg::result_t got;
    slxfr_pkg::result_t want;
    if (!rst_ni) begin
      rx_phase   = slxfr_pkg::PhHunt;
      sync_val   = slxfr_pkg::SyncReset;
      hdr_type   = 8'd0;
      hdr_length = 8'd0;
      pay_count  = 8'd0;
      xor_acc    = 8'd0;
      frame_results.delete();
      pending_o <= 0;
    end else begin
      // compare the result transfer first: it belongs to an earlier byte
      if (m_axis_tvalid && m_axis_tready) begin
        got.valid        = 1'b1;
        got.data_byte    = m_axis_tdata[7:0];
        got.frame_type   = m_axis_tdata[15:8];
        got.frame_length = m_axis_tdata[23:16];
        got.byte_index   = m_axis_tdata[31:24];
        got.end_of_frame = m_axis_tlast;
        got.checksum_ok  = m_axis_tuser;
        if (frame_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with none expected: tdata %08h last %b user %b",
                     $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          want = frame_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: expected data %02h type %02h len %02h",
                        " idx %02h eof %b ok %b, got data %02h type %02h len %02h",
                        " idx %02h eof %b ok %b"}, $realtime,
                       want.data_byte, want.frame_type, want.frame_length,
                       want.byte_index, want.end_of_frame, want.checksum_ok,
                       got.data_byte, got.frame_type, got.frame_length,
                       got.byte_index, got.end_of_frame, got.checksum_ok);
          end
        end
      end
      if (sync_we_i) sync_val = sync_wdata_i;
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
      pending_o <= frame_results.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

FILE: tb/tb_sync_length_xor_frame_receiver_top.sv
// Testbench top for the frame receiver: clock, reset, byte stimulus, result sink and verdict.
module tb_sync_length_xor_frame_receiver_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        sync_we_i;
  logic [7:0]  sync_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent;
  logic [7:0]  cur_sync;
  bit          steady = 1'b0;

  // Hand-picked bytes: edge values, empty frame, sync inside a frame, bad checksums
  logic [7:0] dir_bytes [22] = '{
    8'h00, 8'hFF, 8'h55,                 // dropped while hunting
    8'hAA, 8'h00, 8'h00, 8'h00,          // zero length, good checksum
    8'hAA, 8'hFF, 8'h01, 8'hAA, 8'h54,   // sync value as payload
    8'hAA, 8'h12, 8'h02, 8'h00, 8'hFF, 8'h00, // failed checksum
    8'hAA, 8'hAA, 8'h00, 8'h00           // sync value as type, failed checksum
  };

  logic [7:0] sync_plan [6] = '{8'h00, 8'hFF, 8'h3C, 8'h81, 8'h55, slxfr_pkg::SyncReset};

  sync_length_xor_frame_receiver_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sync_we_i     (sync_we_i),
    .sync_wdata_i  (sync_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  sync_length_xor_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sync_we_i        (sync_we_i),
    .sync_wdata_i     (sync_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sync_length_xor_frame_receiver_top regression: fail");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input bit counted);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (counted) bytes_sent++;
  endtask

  // Send a sync byte and a frame with random content; some are cut short or corrupted
  task automatic send_frame(input int force_len);
    logic [7:0] body[$];
    logic [7:0] ftype;
    logic [7:0] flen;
    logic [7:0] acc;
    logic [7:0] pb;
    int unsigned r;
    int unsigned cut;
    if ($urandom_range(0, 9) == 0) steady = !steady;
    ftype = ($urandom_range(0, 7) == 0) ? cur_sync : 8'($urandom);
    if (force_len >= 0) begin
      flen = 8'(force_len);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 1) flen = 8'($urandom_range(100, 255));
      else if (r < 15) flen = 8'd0;
      else flen = 8'($urandom_range(1, 12));
    end
    body.push_back(ftype);
    body.push_back(flen);
    acc = ftype ^ flen;
    for (int i = 0; i < int'(flen); i++) begin
      pb = ($urandom_range(0, 7) == 0) ? cur_sync : 8'($urandom);
      body.push_back(pb);
      acc = acc ^ pb;
    end
    // one in five checksums is wrong
    if ($urandom_range(0, 4) == 0) body.push_back(acc ^ 8'($urandom_range(1, 255)));
    else body.push_back(acc);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size() - 1) : body.size();
    send_byte(cur_sync, 1'b1);
    for (int i = 0; i < int'(cut); i++) send_byte(body[i], 1'b1);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] v);
    sync_we_i    <= 1'b1;
    sync_wdata_i <= v;
    @(posedge clk_i);
    sync_we_i    <= 1'b0;
    cur_sync = v;
  endtask

  // Result sink: random stall before each transfer
  initial begin : sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    rst_ni        <= 1'b0;
    sync_we_i     <= 1'b0;
    sync_wdata_i  <= 8'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    m_axis_tready <= 1'b0;
    cur_sync   = slxfr_pkg::SyncReset;
    bytes_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bytes under the reset sync value
    foreach (dir_bytes[i]) send_byte(dir_bytes[i], 1'b1);
    drain();

    // random frames under a series of sync values
    foreach (sync_plan[p]) begin
      write_sync(sync_plan[p]);
      bytes_sent = 0;
      // longest frame once, to reach the top payload index
      if (p == 1) send_frame(255);
      while (bytes_sent < PhaseItems) begin
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        send_frame(-1);
      end
      drain();
    end

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("sync_length_xor_frame_receiver_top regression: pass");
    end else begin
      $display("sync_length_xor_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
